// File: rtl/core/upd_pkg.sv
// Shared types, constants and the hex digit decode for the URI percent decoder.
package upd_pkg;

	localparam logic [7:0] PERCENT_CHAR = 8'h25;
	localparam int unsigned HEX_RADIX = 16;
	localparam int unsigned NIBBLE_W = $clog2(HEX_RADIX);
	localparam int unsigned MAX_OUT = 3;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_PCT   = 2'd1,
		PH_DIGIT = 2'd2
	} phase_t;

	// One classified input item: up to three bytes to emit, oldest in slot 0.
	typedef struct packed {
		logic [1:0]               cnt;
		logic                     last;
		logic [MAX_OUT-1:0][7:0]  bytes;
	} cmd_t;

	// Returns {is_hex, nibble} for one character.
	function automatic logic [NIBBLE_W:0] hex_val(input logic [7:0] c);
		logic [NIBBLE_W:0] r;
		r = '0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, c[NIBBLE_W-1:0]};
		end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
			r = {1'b1, c[NIBBLE_W-1:0] + 4'd9};
		end
		return r;
	endfunction

endpackage

// File: rtl/core/upd_front.sv
// Front end: tracks escape state and turns accepted bytes into emit commands.
module upd_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            take,
	input  logic [7:0]      in_byte,
	input  logic            in_last,
	output logic            cmd_vld,
	output upd_pkg::cmd_t   cmd,
	output upd_pkg::phase_t phase
);
	import upd_pkg::*;

	phase_t            phase_q, phase_nxt;
	logic [7:0]        held_q, held_nxt;
	logic [NIBBLE_W:0] hv_in, hv_held;
	logic              fresh_emit;
	cmd_t              cmd_c;

	assign hv_in      = hex_val(in_byte);
	assign hv_held    = hex_val(held_q);
	// A fresh '%' starts an escape unless the string ends here.
	assign fresh_emit = !(in_byte == PERCENT_CHAR && !in_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			held_q  <= '0;
		end else if (take) begin
			phase_q <= phase_nxt;
			held_q  <= held_nxt;
		end
	end

	always_comb begin
		cmd_c       = '0;
		cmd_c.last  = in_last;
		held_nxt    = held_q;
		phase_nxt   = PH_IDLE;
		unique case (phase_q)
			PH_PCT: begin
				if (hv_in[NIBBLE_W]) begin
					if (in_last) begin
						cmd_c.cnt      = 2'd2;
						cmd_c.bytes[0] = PERCENT_CHAR;
						cmd_c.bytes[1] = in_byte;
					end else begin
						held_nxt  = in_byte;
						phase_nxt = PH_DIGIT;
					end
				end else begin
					cmd_c.bytes[0] = PERCENT_CHAR;
					cmd_c.bytes[1] = in_byte;
					cmd_c.cnt      = fresh_emit ? 2'd2 : 2'd1;
					phase_nxt      = fresh_emit ? PH_IDLE : PH_PCT;
				end
			end
			PH_DIGIT: begin
				if (hv_in[NIBBLE_W] && hv_held[NIBBLE_W]) begin
					cmd_c.cnt      = 2'd1;
					cmd_c.bytes[0] = {hv_held[NIBBLE_W-1:0], hv_in[NIBBLE_W-1:0]};
				end else begin
					cmd_c.bytes[0] = PERCENT_CHAR;
					cmd_c.bytes[1] = held_q;
					cmd_c.bytes[2] = in_byte;
					cmd_c.cnt      = fresh_emit ? 2'd3 : 2'd2;
					phase_nxt      = fresh_emit ? PH_IDLE : PH_PCT;
				end
			end
			default: begin
				// Idle and the unused phase code behave as nothing held.
				cmd_c.bytes[0] = in_byte;
				cmd_c.cnt      = fresh_emit ? 2'd1 : 2'd0;
				phase_nxt      = fresh_emit ? PH_IDLE : PH_PCT;
			end
		endcase
	end

	assign cmd     = cmd_c;
	assign cmd_vld = take && (cmd_c.cnt != 2'd0);
	assign phase   = phase_q;

endmodule

// File: rtl/core/upd_cmdq.sv
// Small command queue between the front end and the output serializer.
module upd_cmdq #(
	parameter int unsigned DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  upd_pkg::cmd_t wdata,
	input  logic          rd,
	output upd_pkg::cmd_t rdata,
	output logic          full,
	output logic          nonempty
);
	import upd_pkg::*;

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

	cmd_t          slots_q [DEPTH];
	logic [AW-1:0] wptr_q, rptr_q;
	logic [CW-1:0] count_q;

	assign full     = (count_q == CW'(DEPTH));
	assign nonempty = (count_q != '0);
	assign rdata    = slots_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			slots_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (wr) begin
				wptr_q <= (wptr_q == LAST_IDX) ? '0 : wptr_q + 1'b1;
			end
			if (rd) begin
				rptr_q <= (rptr_q == LAST_IDX) ? '0 : rptr_q + 1'b1;
			end
			if (wr && !rd) begin
				count_q <= count_q + 1'b1;
			end else if (rd && !wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/core/upd_back.sv
// Back end: holds one command and hands out its bytes one per transaction.
module upd_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_nonempty,
	input  upd_pkg::cmd_t q_data,
	output logic          q_rd,
	input  logic          pop,
	output logic          empty,
	output logic [7:0]    out_byte,
	output logic          out_last
);
	import upd_pkg::*;

	cmd_t cur_q;
	logic vld_q;
	logic take_out, drained;

	assign take_out = pop && vld_q;
	assign drained  = !vld_q || (take_out && cur_q.cnt == 2'd1);
	assign q_rd     = q_nonempty && drained;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (drained) begin
			vld_q <= q_nonempty;
		end
	end

	always_ff @(posedge clk) begin
		if (q_rd) begin
			cur_q <= q_data;
		end else if (take_out) begin
			cur_q.cnt   <= cur_q.cnt - 2'd1;
			cur_q.bytes <= {8'h00, cur_q.bytes[MAX_OUT-1:1]};
		end
	end

	assign empty    = !vld_q;
	assign out_byte = cur_q.bytes[0];
	// Only the final byte of a command that ends the string is marked.
	assign out_last = cur_q.last && (cur_q.cnt == 2'd1);

endmodule

// File: rtl/core/uri_percent_decoder.sv
// Top level of the streaming URI percent decoder.
//
//   channel   | handshake        | payload
//   ----------+------------------+-------------------
//   input     | push / full      | in_byte, in_last
//   result    | pop / empty      | out_byte, out_last
//
// One input byte is taken per cycle while full is low; the front end classifies
// it in that cycle and writes its command (up to three bytes), if any, into the
// command queue. The back end delivers one result byte per cycle while pop is
// high and a command is held, which is loaded from the queue. full follows only
// the DEPTH-entry command queue: result stalls raise it, and at the default
// depth it never rises while pop stays high. Reset clears state.
module uri_percent_decoder #(
	parameter int unsigned DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_byte,
	output logic       out_last
);
	import upd_pkg::*;

	logic   take;
	logic   cmd_vld;
	cmd_t   cmd;
	phase_t phase;
	cmd_t   q_data;
	logic   q_rd, q_nonempty;

	assign take = push && !full;

	upd_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.in_byte (in_byte),
		.in_last (in_last),
		.cmd_vld (cmd_vld),
		.cmd     (cmd),
		.phase   (phase)
	);

	upd_cmdq #(.DEPTH(DEPTH)) u_cmdq (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (cmd_vld),
		.wdata    (cmd),
		.rd       (q_rd),
		.rdata    (q_data),
		.full     (full),
		.nonempty (q_nonempty)
	);

	upd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_nonempty (q_nonempty),
		.q_data     (q_data),
		.q_rd       (q_rd),
		.pop        (pop),
		.empty      (empty),
		.out_byte   (out_byte),
		.out_last   (out_last)
	);

	// The end of a string always leaves nothing held.
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(take && in_last) |=> (phase == PH_IDLE))
		else $error("escape state held across end of string");

	// A final byte always produces at least one result.
	a_last_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(take && in_last) |-> cmd_vld)
		else $error("final byte produced no command");

	// Commands written to the queue are never empty.
	a_cmd_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_vld |-> (cmd.cnt != 2'd0))
		else $error("empty command pushed");

endmodule
